>>> hw/rtl/bcomp_pkg.sv
// Shared types and constants for the barometric compensation block.
// No dependencies; imported by bcomp_div and the top level.
package bcomp_pkg;

  localparam int DivBits   = 32;
  localparam int RawTWidth = 16;
  localparam int RawPWidth = 19;
  localparam int TempWidth = 16;
  localparam int PresWidth = 20;
  localparam int CfgWidth  = 32;

  localparam logic [31:0] B6Offset   = 32'd4000;
  localparam logic [31:0] B4Offset   = 32'd32768;
  localparam logic [31:0] PresFactor = 32'd50000;
  localparam logic [31:0] PCoefA     = 32'd3038;
  localparam logic [31:0] PCoefB     = 32'd7357;
  localparam logic [31:0] PCoefC     = 32'd3791;
  localparam logic [31:0] PresMax    = 32'd1048575;

  typedef enum logic [2:0] {
    REG_COEFF0 = 3'd0,
    REG_COEFF1 = 3'd1,
    REG_COEFF2 = 3'd2,
    REG_COEFF3 = 3'd3,
    REG_COEFF4 = 3'd4,
    REG_OSS    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

endpackage

>>> hw/rtl/bcomp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Carries a sideband word alongside each request. Uses bcomp_pkg.
module bcomp_div #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [bcomp_pkg::DivBits-1:0] num,
  input  logic [bcomp_pkg::DivBits-1:0] den,
  input  logic [SW-1:0]                 side_in,
  output logic                          out_valid,
  output logic [bcomp_pkg::DivBits-1:0] quo,
  output logic [SW-1:0]                 side_out
);
  import bcomp_pkg::*;

  localparam int N = DivBits;

  logic          v [0:N];
  logic [N-1:0]  n [0:N];
  logic [N-1:0]  d [0:N];
  logic [N-1:0]  r [0:N];
  logic [N-1:0]  q [0:N];
  logic [SW-1:0] s [0:N];

  assign v[0] = in_valid;
  assign n[0] = num;
  assign d[0] = den;
  assign r[0] = '0;
  assign q[0] = '0;
  assign s[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N:0]   rsh;
    logic [N:0]   diff;
    logic         qbit;
    logic [N-1:0] r_next;

    always_comb begin
      rsh    = {r[i], n[i][N-1]};
      diff   = rsh - {1'b0, d[i]};
      qbit   = !diff[N];
      r_next = qbit ? diff[N-1:0] : rsh[N-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      n[i+1] <= n[i] << 1;
      d[i+1] <= d[i];
      r[i+1] <= r_next;
      q[i+1] <= {q[i][N-2:0], qbit};
      s[i+1] <= s[i];
    end
  end

  assign out_valid = v[N];
  assign quo       = q[N];
  assign side_out  = s[N];

endmodule

>>> hw/rtl/baro_temp_pressure_compensation_top.sv
// Top level of the barometric temperature/pressure compensation pipeline.
// Depends on bcomp_pkg and bcomp_div (two 32-stage dividers).
//
//  channel  | ports                                   | handshake
//  request  | start, raw_temperature, raw_pressure    | start & !busy
//  result   | done, temperature_tenths, pressure_pa,  | done, one cycle
//           | status                                  |
//  config   | cfg_we, cfg_index, cfg_data             | cfg_we
//
// One request per cycle; each accepted request yields one done pulse, and
// results come out in request order.
// The pipeline is the two 32-stage dividers plus 13 arithmetic stages.
// busy is always low. Reset clears the valid bits and the config registers
// (oversampling resets to 3). Results cannot be stalled.
module baro_temp_pressure_compensation_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bcomp_pkg::RawTWidth-1:0] raw_temperature,
  input  logic [bcomp_pkg::RawPWidth-1:0] raw_pressure,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [bcomp_pkg::CfgWidth-1:0]  cfg_data,
  output logic                            done,
  output logic signed [bcomp_pkg::TempWidth-1:0] temperature_tenths,
  output logic [bcomp_pkg::PresWidth-1:0] pressure_pa,
  output logic [1:0]                      status
);
  import bcomp_pkg::*;

  localparam int Latency = 2 * DivBits + 13;
  localparam int Side1W  = 32 + RawPWidth + 2;
  localparam int Side2W  = TempWidth + 4;

  // config registers
  logic [31:0] cfg0, cfg1, cfg2, cfg3, cfg4;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg0 <= '0;
      cfg1 <= '0;
      cfg2 <= '0;
      cfg3 <= '0;
      cfg4 <= '0;
      oss  <= 2'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_COEFF0: cfg0 <= cfg_data;
        REG_COEFF1: cfg1 <= cfg_data;
        REG_COEFF2: cfg2 <= cfg_data;
        REG_COEFF3: cfg3 <= cfg_data;
        REG_COEFF4: cfg4 <= cfg_data;
        REG_OSS:    oss  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0] ac4, ac5, ac6;

  assign ac1 = {{16{cfg0[15]}}, cfg0[15:0]};
  assign ac2 = {{16{cfg0[31]}}, cfg0[31:16]};
  assign ac3 = {{16{cfg1[15]}}, cfg1[15:0]};
  assign ac4 = {16'd0, cfg1[31:16]};
  assign ac5 = {16'd0, cfg2[15:0]};
  assign ac6 = {16'd0, cfg2[31:16]};
  assign b1  = {{16{cfg3[15]}}, cfg3[15:0]};
  assign b2  = {{16{cfg3[31]}}, cfg3[31:16]};
  assign mc  = {{16{cfg4[15]}}, cfg4[15:0]};
  assign md  = {{16{cfg4[31]}}, cfg4[31:16]};

  assign busy = 1'b0;

  // stage 0: capture request
  logic                 v0;
  logic [RawTWidth-1:0] ut0;
  logic [RawPWidth-1:0] up0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    ut0 <= raw_temperature;
    up0 <= raw_pressure;
  end

  // stage 1: (ut - ac6) * ac5
  logic                 v1;
  logic [31:0]          p1;
  logic [RawPWidth-1:0] up1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    p1  <= ({16'd0, ut0} - ac6) * ac5;
    up1 <= up0;
  end

  // stage 2: x1, divisor, operand magnitudes
  logic signed [31:0]   x1c, denc, numc;
  logic                 v2, neg2, dz2;
  logic [31:0]          x1_2, anum2, aden2;
  logic [RawPWidth-1:0] up2;

  always_comb begin
    x1c  = $signed(p1) >>> 15;
    denc = x1c + md;
    numc = mc <<< 11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    x1_2  <= x1c;
    up2   <= up1;
    neg2  <= numc[31] ^ denc[31];
    dz2   <= (denc == 32'sd0);
    anum2 <= numc[31] ? 32'd0 - numc : numc;
    aden2 <= denc[31] ? 32'd0 - denc : denc;
  end

  logic              dv1;
  logic [31:0]       q1;
  logic [Side1W-1:0] s1o;

  bcomp_div #(.SW(Side1W)) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .num       (anum2),
    .den       (aden2),
    .side_in   ({x1_2, up2, neg2, dz2}),
    .out_valid (dv1),
    .quo       (q1),
    .side_out  (s1o)
  );

  logic [31:0]          x1_d;
  logic [RawPWidth-1:0] up_d;
  logic                 neg_d, dz_d;

  assign {x1_d, up_d, neg_d, dz_d} = s1o;

  // stage 3: b5
  logic                 v3, dz3;
  logic [31:0]          b5_3;
  logic [RawPWidth-1:0] up3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= dv1;
    end
    b5_3 <= x1_d + (neg_d ? 32'd0 - q1 : q1);
    up3  <= up_d;
    dz3  <= dz_d;
  end

  // stage 4: temperature and b6
  logic signed [31:0]   tsh;
  logic                 tsat_c;
  logic                 v4, dz4, tsat4;
  logic [TempWidth-1:0] tout4;
  logic [31:0]          b6_4;
  logic [RawPWidth-1:0] up4;

  always_comb begin
    tsh    = $signed(b5_3 + 32'd8) >>> 4;
    tsat_c = !((&tsh[31:15]) || !(|tsh[31:15]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    tsat4 <= tsat_c;
    tout4 <= tsat_c ? (tsh[31] ? 16'h8000 : 16'h7FFF) : tsh[15:0];
    b6_4  <= b5_3 - B6Offset;
    up4   <= up3;
    dz4   <= dz3;
  end

  // stage 5: b6 products
  logic                 v5, dz5, tsat5;
  logic [TempWidth-1:0] tout5;
  logic [31:0]          sqp5, a2_5, a3_5;
  logic [RawPWidth-1:0] up5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    sqp5  <= b6_4 * b6_4;
    a2_5  <= ac2 * b6_4;
    a3_5  <= ac3 * b6_4;
    tsat5 <= tsat4;
    tout5 <= tout4;
    up5   <= up4;
    dz5   <= dz4;
  end

  // stage 6: products with sq
  logic signed [31:0]   sq5;
  logic                 v6, dz6, tsat6;
  logic [TempWidth-1:0] tout6;
  logic [31:0]          m1_6, m2_6, a2_6, a3_6;
  logic [RawPWidth-1:0] up6;

  assign sq5 = $signed(sqp5) >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    m1_6  <= b2 * sq5;
    m2_6  <= b1 * sq5;
    a2_6  <= a2_5;
    a3_6  <= a3_5;
    tsat6 <= tsat5;
    tout6 <= tout5;
    up6   <= up5;
    dz6   <= dz5;
  end

  // stage 7: b3 and x3
  logic signed [31:0]   x3a, b3v, b3c, x3b;
  logic                 v7, dz7, tsat7;
  logic [TempWidth-1:0] tout7;
  logic [31:0]          b3_7, x3b_7;
  logic [RawPWidth-1:0] up7;

  always_comb begin
    x3a = ($signed(m1_6) >>> 11) + ($signed(a2_6) >>> 11);
    b3v = $signed(((ac1 <<< 2) + x3a) << oss) + 32'sd2;
    b3c = $signed(b3v + (b3v[31] ? 32'sd3 : 32'sd0)) >>> 2;
    x3b = $signed(($signed(a3_6) >>> 13) + ($signed(m2_6) >>> 16) + 32'sd2) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    b3_7  <= b3c;
    x3b_7 <= x3b;
    tsat7 <= tsat6;
    tout7 <= tout6;
    up7   <= up6;
    dz7   <= dz6;
  end

  // stage 8: b4 and b7
  logic                 v8, dz8, tsat8;
  logic [TempWidth-1:0] tout8;
  logic [31:0]          b4_8, b7_8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    b4_8  <= (ac4 * (x3b_7 + B4Offset)) >> 15;
    b7_8  <= ({13'd0, up7} - b3_7) * (PresFactor >> oss);
    tsat8 <= tsat7;
    tout8 <= tout7;
    dz8   <= dz7;
  end

  // stage 9: divider operands
  logic                 v9, dz9, tsat9, b4z9, dbl9;
  logic [TempWidth-1:0] tout9;
  logic [31:0]          num9, den9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    dbl9  <= b7_8[31];
    num9  <= b7_8[31] ? b7_8 : b7_8 << 1;
    den9  <= b4_8;
    b4z9  <= (b4_8 == 32'd0);
    tsat9 <= tsat8;
    tout9 <= tout8;
    dz9   <= dz8;
  end

  logic              dv2;
  logic [31:0]       q2;
  logic [Side2W-1:0] s2o;

  bcomp_div #(.SW(Side2W)) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v9),
    .num       (num9),
    .den       (den9),
    .side_in   ({tout9, tsat9, dz9, b4z9, dbl9}),
    .out_valid (dv2),
    .quo       (q2),
    .side_out  (s2o)
  );

  logic [TempWidth-1:0] tout_d;
  logic                 tsat_d, dz2_d, b4z_d, dbl_d;

  assign {tout_d, tsat_d, dz2_d, b4z_d, dbl_d} = s2o;

  // stage 10: p and its products
  logic [31:0]          pc;
  logic signed [31:0]   psh;
  logic                 v10, dz10, tsat10, b4z10;
  logic [TempWidth-1:0] tout10;
  logic [31:0]          p10, pp10, t2_10;

  always_comb begin
    pc  = dbl_d ? q2 << 1 : q2;
    psh = $signed(pc) >>> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= dv2;
    end
    p10    <= pc;
    pp10   <= psh * psh;
    t2_10  <= pc * PCoefB;
    tout10 <= tout_d;
    tsat10 <= tsat_d;
    dz10   <= dz2_d;
    b4z10  <= b4z_d;
  end

  // stage 11
  logic                 v11, dz11, tsat11, b4z11;
  logic [TempWidth-1:0] tout11;
  logic [31:0]          p11, m3_11, x2_11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= v10;
    end
    p11    <= p10;
    m3_11  <= pp10 * PCoefA;
    x2_11  <= $signed(32'd0 - t2_10) >>> 16;
    tout11 <= tout10;
    tsat11 <= tsat10;
    dz11   <= dz10;
    b4z11  <= b4z10;
  end

  // stage 12: final pressure, saturation, status
  logic signed [31:0] pcorr, prc;
  logic               plow, phigh;

  always_comb begin
    pcorr = $signed(($signed(m3_11) >>> 16) + $signed(x2_11) + $signed(PCoefC)) >>> 4;
    prc   = $signed(p11) + pcorr;
    plow  = prc[31];
    phigh = !prc[31] && (prc > $signed(PresMax));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v11;
    end
    if (dz11) begin
      temperature_tenths <= '0;
      pressure_pa        <= '0;
      status             <= STAT_DIV0;
    end else if (b4z11) begin
      temperature_tenths <= tout11;
      pressure_pa        <= '0;
      status             <= STAT_DIV0;
    end else begin
      temperature_tenths <= tout11;
      pressure_pa        <= plow ? '0 : (phigh ? PresMax[PresWidth-1:0] : prc[PresWidth-1:0]);
      status             <= (tsat11 || plow || phigh) ? STAT_SAT : STAT_OK;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("result without matching request");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_DIV0) |-> (pressure_pa == '0))
    else $error("divide-by-zero result carries nonzero pressure");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_DIV0 || status == STAT_SAT))
    else $error("bad status code");
`endif

endmodule

>>> bench/baro_temp_pressure_compensation_top_tb.sv
// Testbench for the barometric compensation pipeline: random and directed
// requests, a built-in integer predictor, and a result queue scoreboard.
// Depends on bcomp_pkg and baro_temp_pressure_compensation_top.
module baro_temp_pressure_compensation_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bcomp_pkg::*;

  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
  } sample_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [19:0] pres;
    logic [1:0]  stat;
  } comp_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [15:0] raw_temperature = '0;
  logic [18:0] raw_pressure = '0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [15:0] temperature_tenths;
  logic [19:0] pressure_pa;
  logic [1:0] status;

  baro_temp_pressure_compensation_top dut (.*);

  sample_t pending_q[$];
  comp_t   expected_q[$];
  logic [31:0] coeff [5];
  logic [1:0]  oss_setting;
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;

  initial forever #4 clk = ~clk;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $unsigned($signed(a) / $signed(b));
  endfunction

  function automatic comp_t compensate(sample_t s);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, tv, pv;
    comp_t r;
    ac1 = sx16(coeff[0][15:0]);  ac2 = sx16(coeff[0][31:16]);
    ac3 = sx16(coeff[1][15:0]);  ac4 = {16'd0, coeff[1][31:16]};
    ac5 = {16'd0, coeff[2][15:0]}; ac6 = {16'd0, coeff[2][31:16]};
    b1 = sx16(coeff[3][15:0]);   b2 = sx16(coeff[3][31:16]);
    mc = sx16(coeff[4][15:0]);   md = sx16(coeff[4][31:16]);
    r = '0;
    x1 = sra(({16'd0, s.ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.stat = STAT_DIV0;
      return r;
    end
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    tv = sra(b5 + 8, 4);
    r.stat = STAT_OK;
    if ($signed(tv) > 32767) begin
      r.temp = 16'h7FFF; r.stat = STAT_SAT;
    end else if ($signed(tv) < -32768) begin
      r.temp = 16'h8000; r.stat = STAT_SAT;
    end else r.temp = tv[15:0];
    b6 = b5 - B6Offset;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(((ac1 * 4 + x3) << oss_setting) + 2, 4);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + B4Offset)) >> 15;
    if (b4 == 0) begin
      r.pres = '0; r.stat = STAT_DIV0;
      return r;
    end
    b7 = ({13'd0, s.up} - b3) * (PresFactor >> oss_setting);
    if (b7 < 32'h8000_0000) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * PCoefA, 16);
    x2 = sra(32'd0 - PCoefB * p, 16);
    pv = p + sra(x1 + x2 + PCoefC, 4);
    if ($signed(pv) < 0) begin
      r.pres = '0; r.stat = STAT_SAT;
    end else if ($signed(pv) > $signed(PresMax)) begin
      r.pres = 20'hFFFFF; r.stat = STAT_SAT;
    end else r.pres = pv[19:0];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && start && !busy) ;
    if (!rst && pending_q.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
      sample_t s;
      s = pending_q[0];
      start <= 1;
      raw_temperature <= s.ut;
      raw_pressure <= s.up;
    end else begin
      start <= 0;
      raw_temperature <= 16'($urandom);
      raw_pressure <= 19'($urandom);
    end
  end

  // acceptance and monitor
  always @(posedge clk) begin
    if (!rst) begin
      bit active;
      active = 0;
      if (start && !busy) begin
        sample_t s;
        s = pending_q.pop_front();
        expected_q.push_back(compensate(s));
        active = 1;
      end
      if (done) begin
        comp_t e;
        active = 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result temp %0d pres %0d status %0d", $realtime,
                   temperature_tenths, pressure_pa, status);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.temp !== temperature_tenths || e.pres !== pressure_pa ||
              e.stat !== status) begin
            $display("%0t: mismatch expected temp %0d pres %0d status %0d, actual %0d %0d %0d",
                     $realtime, $signed(e.temp), e.pres, e.stat, temperature_tenths,
                     pressure_pa, status);
            errors <= errors + 1;
          end
        end
      end
      idle_cycles <= active ? 0 : idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_OSS) oss_setting = val[1:0];
    else coeff[idx] = val;
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic load_coeffs(bit typical);
    if (typical) begin
      write_reg(REG_COEFF0, {16'hFFBA, 16'd408});
      write_reg(REG_COEFF1, {16'd32741, 16'hC76B});
      write_reg(REG_COEFF2, {16'd23153, 16'd32757});
      write_reg(REG_COEFF3, {16'd4, 16'd6190});
      write_reg(REG_COEFF4, {16'd2868, 16'h8000 | 16'h54CE});
      write_reg(REG_COEFF4, {16'd2868, 16'hD4BD});
    end else begin
      write_reg(REG_COEFF0, $urandom);
      write_reg(REG_COEFF1, $urandom);
      write_reg(REG_COEFF2, $urandom);
      write_reg(REG_COEFF3, $urandom);
      write_reg(REG_COEFF4, $urandom);
    end
  endtask

  task automatic add_random(int n);
    sample_t s;
    repeat (n) begin
      s.ut = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(35000, 20000));
      s.up = ($urandom_range(3) == 0) ? 19'($urandom) : 19'($urandom_range(250000, 10000));
      pending_q.push_back(s);
    end
  endtask

  initial begin
    sample_t s;
    coeff = '{default: '0};
    oss_setting = 3;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 0;
    // all-zero coefficients: temperature divisor is zero
    s = '{16'd27898, 19'd23843}; pending_q.push_back(s);
    drain();
    load_coeffs(1);
    write_reg(REG_OSS, 0);
    foreach (s.ut[i]) ;
    pending_q.push_back('{16'd27898, 19'd23843});
    pending_q.push_back('{16'd0, 19'd0});
    pending_q.push_back('{16'hFFFF, 19'h7FFFF});
    pending_q.push_back('{16'hFFFF, 19'd0});
    pending_q.push_back('{16'd0, 19'h7FFFF});
    pending_q.push_back('{16'h8000, 19'h40000});
    pending_q.push_back('{16'h7FFF, 19'h3FFFF});
    drain();
    // temperature divisor zero: x1 = 0 when ut == ac6, md = 0
    write_reg(REG_COEFF4, {16'd0, 16'd2868});
    pending_q.push_back('{16'd23153, 19'd1000});
    drain();
    // INT32_MIN / -1: mc = -32768 (<<11 = -2^26), not min; use md=-1, x1=0
    write_reg(REG_COEFF4, 32'hFFFF_8000);
    pending_q.push_back('{16'd23153, 19'd1000});
    pending_q.push_back('{16'd0, 19'd500});
    drain();
    // saturating extremes
    write_reg(REG_COEFF2, 32'hFFFF_FFFF);
    write_reg(REG_COEFF4, 32'h7FFF_7FFF);
    write_reg(REG_COEFF3, 32'h8000_8000);
    pending_q.push_back('{16'd0, 19'd0});
    pending_q.push_back('{16'hFFFF, 19'h7FFFF});
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      load_coeffs(phase % 2 == 0);
      write_reg(REG_OSS, phase % 4);
      calm = (phase == 3);
      add_random(150);
      drain();
    end
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
